/* hw/rtl/mrf_pkg.sv */
package mrf_pkg;

  localparam logic [7:0]  FcReadCoils    = 8'h01;
  localparam logic [7:0]  FcReadHolding  = 8'h03;
  localparam logic [7:0]  FcReadInput    = 8'h04;
  localparam logic [7:0]  FcWriteCoil    = 8'h05;
  localparam logic [7:0]  FcWriteMulti   = 8'h10;
  localparam logic [7:0]  PadByte        = 8'h00;
  localparam logic [15:0] CrcPoly        = 16'hA001;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [8:0]  ReplyBase      = 9'd5;
  localparam logic [8:0]  ReplyWrite     = 9'd8;
  localparam int unsigned MaxTokens      = 5;

  // Where the decoder stands within a command.
  typedef enum logic [2:0] {
    POS_CODE,
    POS_ADDR_HI,
    POS_ADDR_LO,
    POS_COUNT,
    POS_DATA
  } pos_e;

  // What the emitter puts out for one token.
  typedef enum logic [1:0] {
    TK_DATA,
    TK_CRC_LO,
    TK_CRC_HI
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;
  } tok_t;

  // All frame bytes one command item gives rise to.
  typedef struct packed {
    logic [2:0]                 cnt;
    tok_t [MaxTokens-1:0]       toks;
    logic [8:0]                 reply_len;
    logic                       shrt;
  } grp_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic fc_known(input logic [7:0] fc);
    return (fc == FcReadCoils) || (fc == FcReadHolding) || (fc == FcReadInput) ||
           (fc == FcWriteCoil) || (fc == FcWriteMulti);
  endfunction

endpackage

/* hw/rtl/mrf_cmd_if.sv */
interface mrf_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       cmd_last;

  modport source (output valid, output cmd_byte, output cmd_last, input ready);
  modport sink (input valid, input cmd_byte, input cmd_last, output ready);
endinterface

/* hw/rtl/mrf_frame_if.sv */
interface mrf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  logic [8:0] expected_response_length;
  logic       short_command;

  modport source (output valid, output frame_byte, output frame_last,
                  output expected_response_length, output short_command, input ready);
  modport sink (input valid, input frame_byte, input frame_last,
                input expected_response_length, input short_command, output ready);
endinterface

/* hw/rtl/mrf_decoder.sv */
module mrf_decoder import mrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic [7:0] slave_addr_i,
  output grp_t       grp_o
);

  pos_e       pos_q, pos_d;
  logic [7:0] fc_q, fc_d;
  logic [7:0] left_q, left_d;
  logic [8:0] rlen_q, rlen_d;
  logic       disc_q, disc_d;

  logic [2:0] n;
  logic       close;
  logic       shrt;
  logic [7:0] nb;

  always_comb begin
    pos_d  = pos_q;
    fc_d   = fc_q;
    left_d = left_q;
    rlen_d = rlen_q;
    disc_d = disc_q;
    n      = 3'd0;
    close  = 1'b0;
    shrt   = 1'b0;
    nb     = {byte_i[6:0], 1'b0};
    grp_o  = '0;

    if (disc_q) begin
      disc_d = !last_i;
    end else begin
      case (pos_q)
        POS_CODE: begin
          if (fc_known(byte_i)) begin
            grp_o.toks[0] = '{kind: TK_DATA, data: slave_addr_i};
            grp_o.toks[1] = '{kind: TK_DATA, data: byte_i};
            n      = 3'd2;
            pos_d  = POS_ADDR_HI;
            fc_d   = byte_i;
            left_d = '0;
            rlen_d = (byte_i == FcWriteCoil || byte_i == FcWriteMulti) ? ReplyWrite : ReplyBase;
            close  = last_i;
            shrt   = 1'b1;
          end else begin
            disc_d = !last_i;
          end
        end
        POS_ADDR_HI, POS_ADDR_LO: begin
          grp_o.toks[0] = '{kind: TK_DATA, data: byte_i};
          n     = 3'd1;
          pos_d = (pos_q == POS_ADDR_HI) ? POS_ADDR_LO : POS_COUNT;
          close = last_i;
          shrt  = 1'b1;
        end
        POS_COUNT: begin
          if (fc_q == FcWriteCoil) begin
            grp_o.toks[0] = '{kind: TK_DATA, data: byte_i};
            grp_o.toks[1] = '{kind: TK_DATA, data: PadByte};
          end else begin
            grp_o.toks[0] = '{kind: TK_DATA, data: PadByte};
            grp_o.toks[1] = '{kind: TK_DATA, data: byte_i};
          end
          n = 3'd2;
          if (fc_q == FcReadCoils) begin
            rlen_d = {4'b0, byte_i[7:3]} + ReplyBase;
          end else if (fc_q == FcReadHolding || fc_q == FcReadInput) begin
            rlen_d = {1'b0, nb} + ReplyBase;
          end
          if (fc_q == FcWriteMulti) begin
            grp_o.toks[2] = '{kind: TK_DATA, data: nb};
            n      = 3'd3;
            left_d = nb;
            if (nb == 8'd0) begin
              close = 1'b1;
            end else begin
              pos_d = POS_DATA;
              close = last_i;
              shrt  = 1'b1;
            end
          end else begin
            close = 1'b1;
          end
        end
        POS_DATA: begin
          grp_o.toks[0] = '{kind: TK_DATA, data: byte_i};
          n      = 3'd1;
          left_d = left_q - 8'd1;
          close  = 1'b1;
          shrt   = (left_d != 8'd0);
          if (left_d != 8'd0 && !last_i) close = 1'b0;
        end
        default: begin
          pos_d = POS_CODE;
        end
      endcase
    end

    // CRC low then high closes the frame
    if (close) begin
      grp_o.toks[n]        = '{kind: TK_CRC_LO, data: PadByte};
      grp_o.toks[n + 3'd1] = '{kind: TK_CRC_HI, data: PadByte};
      n      = n + 3'd2;
      pos_d  = POS_CODE;
      left_d = '0;
      disc_d = !last_i;
    end

    grp_o.cnt       = n;
    grp_o.reply_len = rlen_d;
    grp_o.shrt      = close & shrt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_CODE;
      fc_q   <= '0;
      left_q <= '0;
      rlen_q <= '0;
      disc_q <= 1'b0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      fc_q   <= fc_d;
      left_q <= left_d;
      rlen_q <= rlen_d;
      disc_q <= disc_d;
    end
  end

endmodule

/* hw/rtl/mrf_emitter.sv */
module mrf_emitter import mrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  grp_t       grp_i,
  output logic       slot_free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic [8:0] out_len_o,
  output logic       out_short_o
);

  grp_t        grp_q;
  logic        grp_valid_q;
  logic [2:0]  idx_q;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        last_q;
  logic [8:0]  len_q;
  logic        short_q;

  tok_t tok;
  logic pop;
  logic last_pop;
  logic grp_load;

  assign tok      = grp_q.toks[idx_q];
  assign pop      = grp_valid_q && (!out_valid_q || out_ready_i);
  assign last_pop = pop && (idx_q == grp_q.cnt - 3'd1);
  assign grp_load = load_i && (grp_i.cnt != 3'd0);

  assign slot_free_o = !grp_valid_q || last_pop;

  always_comb begin
    crc_d  = crc_q;
    byte_d = tok.data;
    case (tok.kind)
      TK_DATA: begin
        crc_d = crc_byte(crc_q, tok.data);
      end
      TK_CRC_LO: begin
        byte_d = crc_q[7:0];
      end
      TK_CRC_HI: begin
        byte_d = crc_q[15:8];
        crc_d  = CrcInit;
      end
      default: begin
        byte_d = tok.data;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      idx_q       <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      if (grp_load) begin
        grp_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (last_pop) begin
        grp_valid_q <= 1'b0;
      end else if (pop) begin
        idx_q <= idx_q + 3'd1;
      end

      if (pop) begin
        out_valid_q <= 1'b1;
        crc_q       <= crc_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_load) begin
      grp_q <= grp_i;
    end
    if (pop) begin
      byte_q  <= byte_d;
      last_q  <= (tok.kind == TK_CRC_HI);
      len_q   <= (tok.kind == TK_CRC_HI) ? grp_q.reply_len : 9'd0;
      short_q <= (tok.kind == TK_CRC_HI) && grp_q.shrt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_len_o   = len_q;
  assign out_short_o = short_q;

endmodule

/* hw/rtl/modbus_rtu_request_framer.sv */
// Modbus RTU request framer.
// cmd_i carries command bytes (function code, address hi, address lo, count or
// value, then data for function 0x10); cmd_last marks the final one. frame_o
// carries the request frame, one byte per item, ending with the CRC-16 (low
// byte first); the closing byte has frame_last set and carries the expected
// reply length and the short-command flag. cfg_we_i/cfg_wdata_i set the slave
// address, to be written only while the block is idle.
// Each accepted byte's frame bytes wait in a group slot, then leave through the
// output register, which drains one frame byte per cycle while frame_o is ready;
// a byte yielding n frame bytes (0 to 5) holds cmd_i until its last one leaves.
// Data bytes yield one each (the last adds the CRC) and stream at one item per
// cycle. A new command byte is taken while the previous frame bytes still drain.
// When the receiver stalls, frame_o holds its item; cmd_i can still take one
// item into the empty group slot, then stops accepting until that group drains.
// Reset sets the slave address to 1 and returns to the start of a command.
module modbus_rtu_request_framer import mrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrf_cmd_if.sink    cmd_i,
  mrf_frame_if.source frame_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic [7:0] slave_q;
  logic       slot_free;
  logic       accept;
  grp_t       dec_grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= 8'd1;
    end else if (cfg_we_i) begin
      slave_q <= cfg_wdata_i;
    end
  end

  assign cmd_i.ready = slot_free;
  assign accept      = cmd_i.valid && slot_free;

  mrf_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_i       (cmd_i.cmd_byte),
    .last_i       (cmd_i.cmd_last),
    .slave_addr_i (slave_q),
    .grp_o        (dec_grp)
  );

  mrf_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .grp_i       (dec_grp),
    .slot_free_o (slot_free),
    .out_valid_o (frame_o.valid),
    .out_ready_i (frame_o.ready),
    .out_byte_o  (frame_o.frame_byte),
    .out_last_o  (frame_o.frame_last),
    .out_len_o   (frame_o.expected_response_length),
    .out_short_o (frame_o.short_command)
  );

  a_short_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && frame_o.short_command |-> frame_o.frame_last)
    else $error("short flag without frame end");

  a_len_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && frame_o.frame_last |-> frame_o.expected_response_length >= ReplyBase)
    else $error("frame end without reply length");

  a_grp_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> dec_grp.cnt <= 3'(MaxTokens))
    else $error("too many frame bytes for one item");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && !frame_o.ready |=> frame_o.valid && $stable(frame_o.frame_byte))
    else $error("stalled frame byte changed");

endmodule

/* tb/sv/tb_modbus_rtu_request_framer.sv */
`timescale 1ns / 100ps

module tb_modbus_rtu_request_framer import mrf_pkg::*; ();

  localparam int unsigned HangLimit   = 2000;
  localparam int unsigned HoldCycles  = 90;
  localparam int unsigned PhaseItems  = 36;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned NumDirRows  = 28;
  localparam logic [7:0]  BadCodeZero = 8'h00;
  localparam logic [7:0]  BadCodeTop  = 8'hFF;
  localparam logic [39:0] NoBytes     = 40'h0;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       flast;
    logic [8:0] resp_len;
    logic       shrt;
  } frame_rec_t;

  // One command byte of the directed part. Rows with typed set carry their
  // frame bytes in fb (first byte leftmost); the others go to the predictor.
  typedef struct packed {
    logic [7:0]      cmd;
    logic            last;
    logic            typed;
    logic [2:0]      n;
    logic [0:4][7:0] fb;
    logic            closes;
    logic [8:0]      rlen;
    logic            shrt;
  } stim_row_t;

  localparam stim_row_t DirTab [NumDirRows] = '{
    // known frame: 01 03 00 00 00 0A C5 CD
    '{FcReadHolding, 1'b0, 1'b1, 3'd2, {8'h01, FcReadHolding, 24'h0}, 1'b0, 9'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 3'd1, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 3'd1, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h0A, 1'b1, 1'b1, 3'd4, 40'h00_0A_C5_CD_00, 1'b1, 9'd25, 1'b0},
    // unknown codes, with and without trailing bytes
    '{BadCodeZero, 1'b0, 1'b1, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{BadCodeTop, 1'b1, 1'b1, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    // coils, max count, then junk after the complete frame
    '{FcReadCoils, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h55, 1'b0, 1'b1, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'hAA, 1'b1, 1'b1, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    // command ends on its code byte
    '{FcWriteCoil, 1'b1, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    // write multi with count 0x80: byte count wraps to zero, no data
    '{FcWriteMulti, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h02, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    // ends before the count byte
    '{FcReadInput, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h12, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h34, 1'b1, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    // write multi, 4 data bytes declared, only 2 arrive
    '{FcWriteMulti, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'h02, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'hAB, 1'b0, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0},
    '{8'hCD, 1'b1, 1'b0, 3'd0, NoBytes, 1'b0, 9'd0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [7:0] cfg_wdata_i;

  mrf_cmd_if   cmd_if ();
  mrf_frame_if frame_if ();

  modbus_rtu_request_framer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_if),
    .frame_o     (frame_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // framer state as seen by the predictor
  logic [7:0]  slave_reg = 8'h01;
  pos_e        at_pos = POS_CODE;
  logic [7:0]  fc_reg = 8'h00;
  logic [15:0] crc_reg = CrcInit;
  logic [8:0]  data_left = '0;
  logic [8:0]  reply_len = '0;
  logic        dropping = 1'b0;

  frame_rec_t  new_frame_bytes[$];
  frame_rec_t  frames_due[$];
  int unsigned mismatches = 0;
  bit          steady = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned quiet_cycles = 0;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic bit is_modbus_code(input logic [7:0] b);
    case (b)
      FcReadCoils, FcReadHolding, FcReadInput, FcWriteCoil, FcWriteMulti: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_rec(input logic [7:0] b, input logic fl,
                                   input logic [8:0] rl, input logic s);
    frame_rec_t r;
    r.fbyte = b;
    r.flast = fl;
    r.resp_len = rl;
    r.shrt = s;
    new_frame_bytes.push_back(r);
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    int k;
    push_rec(b, 1'b0, '0, 1'b0);
    crc_reg = crc_reg ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      crc_reg = crc_reg[0] ? ((crc_reg >> 1) ^ CrcPoly) : (crc_reg >> 1);
    end
  endfunction

  function automatic void close_frame(input logic s, input logic l);
    push_rec(crc_reg[7:0], 1'b0, '0, 1'b0);
    push_rec(crc_reg[15:8], 1'b1, reply_len, s);
    at_pos = POS_CODE;
    crc_reg = CrcInit;
    data_left = '0;
    dropping = !l;
  endfunction

  // Frame bytes caused by one command byte, left in new_frame_bytes.
  function automatic void predict_frame(input logic [7:0] b, input logic l);
    logic       closed;
    logic [7:0] nb;
    closed = 1'b0;
    new_frame_bytes.delete();
    if (dropping) begin
      if (l) dropping = 1'b0;
      return;
    end
    case (at_pos)
      POS_CODE: begin
        if (!is_modbus_code(b)) begin
          dropping = !l;
          return;
        end
        fc_reg = b;
        crc_reg = CrcInit;
        data_left = '0;
        reply_len = (b == FcWriteCoil || b == FcWriteMulti) ? ReplyWrite : ReplyBase;
        emit_byte(slave_reg);
        emit_byte(b);
        at_pos = POS_ADDR_HI;
      end
      POS_ADDR_HI: begin
        emit_byte(b);
        at_pos = POS_ADDR_LO;
      end
      POS_ADDR_LO: begin
        emit_byte(b);
        at_pos = POS_COUNT;
      end
      POS_COUNT: begin
        if (fc_reg == FcWriteCoil) begin
          emit_byte(b);
          emit_byte(PadByte);
        end else begin
          emit_byte(PadByte);
          emit_byte(b);
        end
        nb = {b[6:0], 1'b0};
        if (fc_reg == FcReadCoils) reply_len = 9'(b >> 3) + ReplyBase;
        else if (fc_reg == FcReadHolding || fc_reg == FcReadInput)
          reply_len = 9'(nb) + ReplyBase;
        if (fc_reg == FcWriteMulti) begin
          emit_byte(nb);
          data_left = 9'(nb);
          if (nb == 8'h00) begin
            close_frame(1'b0, l);
            closed = 1'b1;
          end else begin
            at_pos = POS_DATA;
          end
        end else begin
          close_frame(1'b0, l);
          closed = 1'b1;
        end
      end
      default: begin
        emit_byte(b);
        data_left = data_left - 9'd1;
        if (data_left == 9'd0) begin
          close_frame(1'b0, l);
          closed = 1'b1;
        end
      end
    endcase
    if (!closed && l) close_frame(1'b1, l);
  endfunction

  // Offers one command byte, waits for it to be taken, then predicts.
  task automatic send_item(input logic [7:0] b, input logic l, input bit keep,
                           output int unsigned n);
    while (!steady && $urandom_range(0, 99) < 27) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd_byte <= b;
    cmd_if.cmd_last <= l;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    predict_frame(b, l);
    n = new_frame_bytes.size();
    if (keep) begin
      foreach (new_frame_bytes[i]) frames_due.push_back(new_frame_bytes[i]);
    end
  endtask

  // Mostly well-formed commands with random content; some unknown codes,
  // early ends and trailing junk.
  task automatic send_random_command(inout int unsigned taken);
    logic [7:0]  bytes[$];
    logic [7:0]  code;
    logic [7:0]  cnt;
    int unsigned n;
    int unsigned keep_len;
    int unsigned pick;
    if ($urandom_range(0, 99) < 10) begin
      do code = 8'($urandom()); while (is_modbus_code(code));
      bytes.push_back(code);
      repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom()));
    end else begin
      case ($urandom_range(0, 4))
        0: code = FcReadCoils;
        1: code = FcReadHolding;
        2: code = FcReadInput;
        3: code = FcWriteCoil;
        default: code = FcWriteMulti;
      endcase
      cnt = 8'($urandom());
      if (code == FcWriteMulti) begin
        pick = $urandom_range(0, 39);
        case (pick)
          0: cnt = 8'h00;
          1: cnt = 8'h80;
          2: cnt = 8'h81;
          3: cnt = 8'h7F;
          default: cnt = 8'($urandom_range(1, 4));
        endcase
      end
      bytes.push_back(code);
      bytes.push_back(8'($urandom()));
      bytes.push_back(8'($urandom()));
      bytes.push_back(cnt);
      if (code == FcWriteMulti) begin
        repeat (int'({cnt[6:0], 1'b0})) bytes.push_back(8'($urandom()));
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        keep_len = $urandom_range(1, bytes.size() - 1);
        while (bytes.size() > keep_len) void'(bytes.pop_back());
      end else if (pick < 25) begin
        repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom()));
      end
    end
    foreach (bytes[i]) begin
      send_item(bytes[i], i == bytes.size() - 1, 1'b1, n);
      if (n > 0) taken++;
    end
  endtask

  task automatic set_slave(input logic [7:0] addr);
    while (frames_due.size() != 0) @(posedge clk_i);
    // trailing dropped bytes may still be in flight
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    slave_reg = addr;
  endtask

  always @(posedge clk_i) begin : frame_check
    frame_rec_t want;
    if (rst_ni && frame_if.valid && frame_if.ready) begin
      if (frames_due.size() == 0) begin
        flag_mismatch($sformatf("frame item %h with nothing expected", frame_if.frame_byte));
      end else begin
        want = frames_due.pop_front();
        if (frame_if.frame_byte !== want.fbyte)
          flag_mismatch($sformatf("frame_byte %h, want %h", frame_if.frame_byte, want.fbyte));
        if (frame_if.frame_last !== want.flast)
          flag_mismatch($sformatf("frame_last %b, want %b", frame_if.frame_last, want.flast));
        if (frame_if.expected_response_length !== want.resp_len)
          flag_mismatch($sformatf("expected_response_length %0d, want %0d",
                                  frame_if.expected_response_length, want.resp_len));
        if (frame_if.short_command !== want.shrt)
          flag_mismatch($sformatf("short_command %b, want %b",
                                  frame_if.short_command, want.shrt));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (frame_if.valid && frame_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("timeout: no item moved for %0d cycles", HangLimit);
      $display("tb_modbus_rtu_request_framer NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // frame receiver: random stalls, plus long hold-offs on request
  initial begin
    frame_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        holds_done++;
        repeat (HoldCycles) begin
          frame_if.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      frame_if.ready <= steady || ($urandom_range(0, 99) >= 27);
    end
  end

  initial begin
    int unsigned n;
    int unsigned taken;
    stim_row_t   row;
    frame_rec_t  r;
    cmd_if.valid <= 1'b0;
    cmd_if.cmd_byte <= 8'h00;
    cmd_if.cmd_last <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      row = DirTab[i];
      send_item(row.cmd, row.last, !row.typed, n);
      if (row.typed) begin
        for (int j = 0; j < row.n; j++) begin
          r.fbyte = row.fb[j];
          r.flast = row.closes && (j == row.n - 1);
          r.resp_len = r.flast ? row.rlen : 9'd0;
          r.shrt = r.flast ? row.shrt : 1'b0;
          frames_due.push_back(r);
        end
      end
    end
    cmd_if.valid <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      set_slave((p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom()));
      steady = (p == 2);
      if (p == 1 || p == 4) holds_asked++;
      taken = 0;
      while (taken < PhaseItems) send_random_command(taken);
      cmd_if.valid <= 1'b0;
    end
    steady = 1'b0;

    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_modbus_rtu_request_framer OK");
    end else begin
      $display("tb_modbus_rtu_request_framer NOT OK");
    end
    $finish;
  end

endmodule
